### hdl/timed_differential_drive_queue_defines.svh
// Assertion macros for the checker file.
`ifndef TIMED_DIFFERENTIAL_DRIVE_QUEUE_DEFINES_SVH
`define TIMED_DIFFERENTIAL_DRIVE_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TDDQ_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define TDDQ_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tddq_pkg.sv
package tddq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int HEADING_W = 9;
  localparam int TIME_W = 32;
  localparam int SPEED_W = 8;
  localparam int DRIVE_W = 11;

  localparam logic [HEADING_W-1:0] HEADING_MAX = 9'd359;

  // floor(p / 90) == (p * MIX_RECIP) >> MIX_SHIFT for every p below 2**16
  localparam int MIX_SHIFT = 23;
  localparam logic [16:0] MIX_RECIP = 17'd93207;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_QUEUE = 2'd1,
    ACT_GO    = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_STARTED = 2'd1,
    EV_STOPPED = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MIX1,
    S_MIX2,
    S_APPLY
  } back_state_t;

  typedef struct packed {
    action_t                kind;
    logic [HEADING_W-1:0]   heading;
    logic [TIME_W-1:0]      run_time;
    logic [SPEED_W-1:0]     speed;
  } item_t;

  typedef struct packed {
    logic [HEADING_W-1:0]   heading;
    logic [TIME_W-1:0]      run_time;
    logic [SPEED_W-1:0]     speed;
  } store_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

### hdl/tddq_item_fifo.sv
module tddq_item_fifo
  import tddq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  item_t        push_item,
  input  logic         pop,
  output item_t        head_item,
  output fifo_status_t status
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head_item    = slots[rd_ptr];
  assign status.full  = (fill == 2'd2);
  assign status.empty = (fill == 2'd0);

endmodule

### hdl/tddq_front.sv
module tddq_front
  import tddq_pkg::*;
(
  input  logic                 start,
  input  logic [1:0]           action,
  input  logic [HEADING_W-1:0] heading,
  input  logic [TIME_W-1:0]    run_time,
  input  logic [SPEED_W-1:0]   drive_speed,
  input  fifo_status_t         status,
  output logic                 busy,
  output logic                 push,
  output item_t                push_item
);

  // take a request whenever the item queue has a free slot
  assign busy = status.full;
  assign push = start && !status.full;

  always_comb begin
    push_item.kind     = action_t'(action);
    push_item.heading  = (heading > HEADING_MAX) ? HEADING_MAX : heading;
    push_item.run_time = run_time;
    push_item.speed    = drive_speed;
  end

endmodule

### hdl/tddq_back.sv
module tddq_back
  import tddq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  item_t                     head_item,
  input  fifo_status_t              status,
  output logic                      pop,
  output logic                      done,
  output logic signed [DRIVE_W-1:0] right_drive,
  output logic signed [DRIVE_W-1:0] left_drive,
  output logic                      power_on,
  output logic [1:0]                event_code,
  output logic                      accepted
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

  back_state_t state, state_next;

  store_entry_t mem [QUEUE_DEPTH];
  store_entry_t rd_data;

  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;
  logic [TIME_W-1:0] ticks_left;
  logic              idle_flag;
  logic signed [DRIVE_W-1:0] cur_right;
  logic signed [DRIVE_W-1:0] cur_left;
  logic              power_level;
  event_t            ev;
  logic              acc;

  logic [HEADING_W-1:0] st_heading;
  logic [TIME_W-1:0]    st_time;
  logic [SPEED_W-1:0]   st_speed;
  logic [1:0]           quad;
  logic [15:0]          prod;
  logic [8:0]           quot;

  logic [TIME_W-1:0] tl_dec;
  logic              count_zero;
  logic              queue_full;
  logic              mem_we;
  logic [CNT_W:0]    wr_sum;
  logic [PTR_W-1:0]  waddr;
  logic [PTR_W-1:0]  rptr_inc;
  logic              tick_start;

  logic [1:0]  quad_next;
  logic [6:0]  offset;
  logic [15:0] prod_next;
  logic [32:0] recip_prod;
  logic signed [DRIVE_W-1:0] sv, qv, r_mix, l_mix;

  assign tl_dec     = (ticks_left != '0) ? ticks_left - 1'b1 : '0;
  assign count_zero = (count == '0);
  assign queue_full = (count == DEPTH_C);
  assign wr_sum     = (CNT_W + 1)'(rptr) + (CNT_W + 1)'(count);
  assign waddr      = (wr_sum >= DEPTH_X) ? PTR_W'(wr_sum - DEPTH_X) : PTR_W'(wr_sum);
  assign rptr_inc   = (rptr == LAST_P) ? '0 : rptr + 1'b1;
  assign tick_start = !idle_flag && (tl_dec == '0) && !count_zero;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!status.empty) begin
          case (head_item.kind)
            ACT_TICK: if (tick_start) state_next = S_READ;
            ACT_GO:   state_next = S_MIX1;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_READ:  state_next = S_MIX1;
      S_MIX1:  state_next = S_MIX2;
      S_MIX2:  state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop    = 1'b0;
    mem_we = 1'b0;
    case (state)
      S_IDLE: begin
        pop    = !status.empty;
        mem_we = !status.empty && (head_item.kind == ACT_QUEUE) && !queue_full;
      end
      default: begin
        pop    = 1'b0;
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= '{head_item.heading, head_item.run_time, head_item.speed};
    end
    rd_data <= mem[rptr];
  end

  // quadrant and offset into it
  always_comb begin
    case (st_heading) inside
      [9'd0:9'd89]: begin
        quad_next = 2'd0;
        offset    = 7'(st_heading);
      end
      [9'd90:9'd179]: begin
        quad_next = 2'd1;
        offset    = 7'(st_heading - 9'd90);
      end
      [9'd180:9'd269]: begin
        quad_next = 2'd2;
        offset    = 7'(st_heading - 9'd180);
      end
      default: begin
        quad_next = 2'd3;
        offset    = 7'(st_heading - 9'd270);
      end
    endcase
    prod_next  = 16'(offset) * 16'({st_speed, 1'b0});
    recip_prod = 33'(prod) * 33'(MIX_RECIP);
  end

  always_comb begin
    sv = DRIVE_W'({3'b000, st_speed});
    qv = DRIVE_W'({2'b00, quot});
    case (quad)
      2'd0: begin
        l_mix = sv;
        r_mix = sv - qv;
      end
      2'd1: begin
        l_mix = sv - qv;
        r_mix = -sv;
      end
      2'd2: begin
        l_mix = -sv;
        r_mix = qv - sv;
      end
      default: begin
        l_mix = qv - sv;
        r_mix = sv;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        st_heading <= head_item.heading;
        st_time    <= head_item.run_time;
        st_speed   <= head_item.speed;
      end
      S_READ: begin
        st_heading <= rd_data.heading;
        st_time    <= rd_data.run_time;
        st_speed   <= rd_data.speed;
      end
      S_MIX1: begin
        quad <= quad_next;
        prod <= prod_next;
      end
      S_MIX2: quot <= 9'(recip_prod >> MIX_SHIFT);
      default: quot <= quot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rptr        <= '0;
      count       <= '0;
      ticks_left  <= '0;
      idle_flag   <= 1'b1;
      cur_right   <= '0;
      cur_left    <= '0;
      power_level <= 1'b0;
      done        <= 1'b0;
      ev          <= EV_NONE;
      acc         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            ev  <= EV_NONE;
            acc <= 1'b0;
            case (head_item.kind)
              ACT_TICK: begin
                done <= 1'b1;
                if (!idle_flag) begin
                  ticks_left <= tl_dec;
                  if (tl_dec == '0) begin
                    if (count_zero) begin
                      cur_right   <= '0;
                      cur_left    <= '0;
                      power_level <= 1'b0;
                      idle_flag   <= 1'b1;
                      ev          <= EV_STOPPED;
                    end else begin
                      rptr  <= rptr_inc;
                      count <= count - 1'b1;
                      done  <= 1'b0;
                    end
                  end
                end
              end
              ACT_QUEUE: begin
                done <= 1'b1;
                if (!queue_full) begin
                  acc   <= 1'b1;
                  count <= count + 1'b1;
                  if (idle_flag) begin
                    idle_flag  <= 1'b0;
                    ticks_left <= '0;
                  end
                end
              end
              ACT_GO: begin
                rptr  <= '0;
                count <= '0;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_APPLY: begin
          done       <= 1'b1;
          ev         <= EV_STARTED;
          ticks_left <= st_time;
          idle_flag  <= 1'b0;
          if (st_speed == '0) begin
            cur_right   <= '0;
            cur_left    <= '0;
            power_level <= 1'b0;
          end else begin
            cur_right   <= r_mix <<< 2;
            cur_left    <= l_mix <<< 2;
            power_level <= 1'b1;
          end
        end
        default: done <= 1'b0;
      endcase
    end
  end

  assign right_drive = cur_right;
  assign left_drive  = cur_left;
  assign power_on    = power_level;
  assign event_code  = ev;
  assign accepted    = acc;

endmodule

### hdl/timed_differential_drive_queue.sv
// Path: tick, queue and ignored requests pass the request queue, then the done register;
// a go request passes two mixer stages and the apply stage; a tick that starts a queued
// command passes the command store read, the two mixer stages (offset product, then
// reciprocal multiply for the divide by 90) and then the apply stage that loads the drives.
// Throughput: 1 request per cycle for non-starting requests; the back takes no new request
// while a command starts; the front keeps filling the 2-entry request queue meanwhile.
// Reset (rst, synchronous, active high): queues empty, idle, motors off, drives zero.
module timed_differential_drive_queue
  import tddq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                action,
  input  logic [HEADING_W-1:0]      heading,
  input  logic [TIME_W-1:0]         run_time,
  input  logic [SPEED_W-1:0]        drive_speed,
  output logic                      done,
  output logic signed [DRIVE_W-1:0] right_drive,
  output logic signed [DRIVE_W-1:0] left_drive,
  output logic                      power_on,
  output logic [1:0]                event_code,
  output logic                      accepted
);

  // Front: decode the action and clamp the heading, push the request.
  // Request queue: two slots between front and back.
  // Back: command store, tick countdown and the quadrant mixer.
  fifo_status_t status;
  logic         push;
  logic         pop;
  item_t        push_item;
  item_t        head_item;

  tddq_front u_front (
    .start       (start),
    .action      (action),
    .heading     (heading),
    .run_time    (run_time),
    .drive_speed (drive_speed),
    .status      (status),
    .busy        (busy),
    .push        (push),
    .push_item   (push_item)
  );

  // hold requests here while the back is busy starting a command
  tddq_item_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (status)
  );

  // one result strobe per request, in request order
  tddq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_item   (head_item),
    .status      (status),
    .pop         (pop),
    .done        (done),
    .right_drive (right_drive),
    .left_drive  (left_drive),
    .power_on    (power_on),
    .event_code  (event_code),
    .accepted    (accepted)
  );

endmodule

### hdl/tddq_checker.sv
`include "timed_differential_drive_queue_defines.svh"

module tddq_checker
  import tddq_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      done,
  input logic signed [DRIVE_W-1:0] right_drive,
  input logic signed [DRIVE_W-1:0] left_drive,
  input logic                      power_on,
  input logic [1:0]                event_code,
  input logic                      accepted
);

  `TDDQ_CHECK(a_off_means_zero, !power_on, (right_drive == '0) && (left_drive == '0),
              "drive while power off")
  `TDDQ_CHECK(a_accept_no_event, done && accepted, event_code == EV_NONE,
              "stored request with event")
  `TDDQ_CHECK(a_drive_moves_with_done, !$past(rst) && !$stable(right_drive), done,
              "drive changed without result")
  `TDDQ_CHECK_NEXT(a_stop_stays_off, done && (event_code == EV_STOPPED), !power_on,
                   "power on after stop")

endmodule

bind timed_differential_drive_queue tddq_checker u_tddq_checker (.*);
